>>> hdl/d2q9_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// d2q9_pkg
// Shared widths, lattice tables and Q16.16 helpers for the D2Q9 collision node.
// ----------------------------------------------------------------------------
package d2q9_pkg;

	localparam int DW       = 32;           // Q16.16 word
	localparam int QB       = 16;           // fraction bits
	localparam int RW       = 18;           // relax rate width
	localparam int NDIR     = 9;
	localparam int DIVW     = DW + QB;      // dividend width, momentum << 16
	localparam int DIV_LAT  = DIVW + 2;     // prep + one bit per stage + saturate
	localparam int LANE_LAT = 9;

	typedef logic signed [DW-1:0] q_t;

	localparam logic [RW-1:0] RATE_RESET = 18'd109227;

	localparam q_t Q_ONE        = 32'sd65536;
	localparam q_t C_THREE      = 32'sd196608;
	localparam q_t C_NINE_HALF  = 32'sd294912;
	localparam q_t C_THREE_HALF = 32'sd98304;
	localparam q_t W_REST       = 32'sd29127;
	localparam q_t W_AXIS       = 32'sd7282;
	localparam q_t W_DIAG       = 32'sd1820;

	localparam int DIR_X   [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
	localparam int DIR_Y   [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
	localparam int DIR_OPP [NDIR] = '{0, 3, 4, 1, 2, 7, 8, 5, 6};
	localparam q_t DIR_W   [NDIR] = '{W_REST, W_AXIS, W_AXIS, W_AXIS, W_AXIS,
		W_DIAG, W_DIAG, W_DIAG, W_DIAG};

	function automatic q_t sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -64'sd2147483648)
			return 32'sh80000000;
		else
			return v[DW-1:0];
	endfunction

	// exact product -> floor by 16 -> saturate
	function automatic q_t qfloor(input logic signed [63:0] p);
		logic signed [63:0] s;
		s = p >>> QB;
		return sat32(s);
	endfunction

endpackage
`default_nettype wire

>>> hdl/d2q9_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// d2q9_div
// Pipelined restoring divider: (num * 65536) / den, truncated, saturated; zero if den <= 0.
// ----------------------------------------------------------------------------
module d2q9_div import d2q9_pkg::*; (
	input  wire logic clk,
	input  wire logic en,
	input  wire q_t   num,
	input  wire q_t   den,
	output q_t        quo
);

	logic [DIVW-1:0] acc_s [0:DIVW];
	logic [DW-2:0]   rem_s [0:DIVW];
	logic [DW-2:0]   den_s [0:DIVW];
	logic            neg_s [0:DIVW];
	logic            pos_s [0:DIVW];
	q_t              quo_q;

	logic [DW-1:0] nmag;
	logic          dpos;
	assign nmag = num[DW-1] ? (~num + 1'b1) : num;
	assign dpos = !den[DW-1] && (den != '0);

	always_ff @(posedge clk) begin
		if (en) begin
			acc_s[0] <= {nmag, {QB{1'b0}}};
			rem_s[0] <= '0;
			den_s[0] <= dpos ? den[DW-2:0] : (DW-1)'(1);
			neg_s[0] <= num[DW-1];
			pos_s[0] <= dpos;
		end
	end

	for (genvar i = 0; i < DIVW; i++) begin : g_bit
		logic [DW-1:0] trial;
		logic          ge;
		logic [DW-1:0] nrem;
		assign trial = {rem_s[i], acc_s[i][DIVW-1]};
		assign ge    = trial >= {1'b0, den_s[i]};
		// remainder stays below the divisor, so it fits in DW-1 bits
		assign nrem  = ge ? (trial - {1'b0, den_s[i]}) : trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= nrem[DW-2:0];
				acc_s[i+1] <= {acc_s[i][DIVW-2:0], ge};
				den_s[i+1] <= den_s[i];
				neg_s[i+1] <= neg_s[i];
				pos_s[i+1] <= pos_s[i];
			end
		end
	end

	logic [DIVW-1:0] qm;
	assign qm = acc_s[DIVW];

	always_ff @(posedge clk) begin
		if (en) begin
			if (!pos_s[DIVW])
				quo_q <= '0;
			else if (neg_s[DIVW])
				quo_q <= (qm > DIVW'(64'h80000000)) ? 32'sh80000000 : -q_t'(qm[DW-1:0]);
			else
				quo_q <= (qm > DIVW'(64'h7fffffff)) ? 32'sh7fffffff : q_t'(qm[DW-1:0]);
		end
	end

	assign quo = quo_q;

endmodule
`default_nettype wire

>>> hdl/d2q9_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// d2q9_lane
// One direction: equilibrium and BGK relaxation, nine register stages.
// ----------------------------------------------------------------------------
module d2q9_lane import d2q9_pkg::*; #(
	parameter int DIR = 0
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire q_t            ux,
	input  wire q_t            uy,
	input  wire q_t            rho,
	input  wire q_t            dist_in,
	input  wire q_t            c4,     // 3/2 |u|^2, valid with stage 4
	input  wire logic [RW-1:0] rate,
	output q_t                 result,
	output q_t                 dist_out
);

	localparam int DX = DIR_X[DIR];
	localparam int DY = DIR_Y[DIR];
	localparam q_t WK = DIR_W[DIR];

	logic signed [DW+1:0] tx, ty;
	assign tx = (DX > 0) ? (DW+2)'(ux) : (DX < 0) ? -(DW+2)'(ux) : '0;
	assign ty = (DY > 0) ? (DW+2)'(uy) : (DY < 0) ? -(DW+2)'(uy) : '0;

	q_t eu_s1, rho_s1;
	logic signed [63:0] p3_s2, pee_s2, wr_s2;
	q_t t3_s3, ee_s3, wrq_s3;
	logic signed [63:0] p45_s4;
	q_t t3_s4, wrq_s4;
	q_t br_s5, wrq_s5;
	logic signed [63:0] pf_s6;
	logic signed [DW:0] diff_s7;
	logic signed [DW+RW:0] pd_s8;
	q_t res_s9;
	q_t d_s [1:LANE_LAT];

	logic signed [RW:0] rate_sx;
	assign rate_sx = {1'b0, rate};

	logic signed [63:0] br_sum;
	assign br_sum = 64'(Q_ONE) + 64'(t3_s4) + 64'(qfloor(p45_s4)) - 64'(c4);

	q_t feq;
	assign feq = qfloor(pf_s6);

	always_ff @(posedge clk) begin
		if (en) begin
			eu_s1   <= sat32(64'(tx + ty));
			rho_s1  <= rho;
			p3_s2   <= eu_s1 * C_THREE;
			pee_s2  <= eu_s1 * eu_s1;
			wr_s2   <= rho_s1 * WK;
			t3_s3   <= qfloor(p3_s2);
			ee_s3   <= qfloor(pee_s2);
			wrq_s3  <= qfloor(wr_s2);
			p45_s4  <= ee_s3 * C_NINE_HALF;
			t3_s4   <= t3_s3;
			wrq_s4  <= wrq_s3;
			br_s5   <= sat32(br_sum);
			wrq_s5  <= wrq_s4;
			pf_s6   <= wrq_s5 * br_s5;
			diff_s7 <= (DW+1)'(d_s[6]) - (DW+1)'(feq);
			pd_s8   <= diff_s7 * rate_sx;
			res_s9  <= sat32(64'(d_s[8]) - (64'(pd_s8) >>> QB));
			d_s[1]  <= dist_in;
			for (int i = 2; i <= LANE_LAT; i++)
				d_s[i] <= d_s[i-1];
		end
	end

	assign result   = res_s9;
	assign dist_out = d_s[LANE_LAT];

endmodule
`default_nettype wire

>>> hdl/d2q9_bgk_node_collision.sv
`default_nettype none
// ----------------------------------------------------------------------------
// d2q9_bgk_node_collision
// D2Q9 BGK collision for one lattice node per clock, Q16.16 with saturation.
// ----------------------------------------------------------------------------
// Takes one node word per clock (nine streamed distributions plus a wall
// flag) and returns one word per clock: nine post-collision distributions,
// density and velocity. The pipeline is one block: the input register, a
// density/momentum adder stage, two 50-stage restoring dividers for ux and
// uy (a prep stage, one quotient bit per stage, a saturate stage), nine
// parallel direction lanes of 9 stages each for equilibrium and relaxation,
// and a merge stage that picks bounce-back for wall nodes and loads the
// output register. The whole pipe advances unless the output word is held
// by out_stall, so in_stall simply mirrors a stalled full output.
// relax_rate is written through the cfg port (always ready); write it only
// while no node is in flight. No clearing pass after reset.
// ----------------------------------------------------------------------------
module d2q9_bgk_node_collision import d2q9_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// node words in
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic          is_solid,
	input  wire q_t            dist_0,
	input  wire q_t            dist_1,
	input  wire q_t            dist_2,
	input  wire q_t            dist_3,
	input  wire q_t            dist_4,
	input  wire q_t            dist_5,
	input  wire q_t            dist_6,
	input  wire q_t            dist_7,
	input  wire q_t            dist_8,
	// result words out
	output logic               out_valid,
	input  wire logic          out_stall,
	output q_t                 new_0,
	output q_t                 new_1,
	output q_t                 new_2,
	output q_t                 new_3,
	output q_t                 new_4,
	output q_t                 new_5,
	output q_t                 new_6,
	output q_t                 new_7,
	output q_t                 new_8,
	output q_t                 density,
	output q_t                 velocity_x,
	output q_t                 velocity_y,
	// relax rate write
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [RW-1:0] relax_rate
);

	localparam int NV = 2 + DIV_LAT + LANE_LAT;

	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;
	assign cfg_ready = 1'b1;

	// relax rate register
	logic [RW-1:0] rate_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rate_q <= RATE_RESET;
		else if (cfg_valid)
			rate_q <= relax_rate;
	end

	// valid tracking down the pipe
	logic vld_s [0:NV-1];
	logic out_vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NV; i++)
				vld_s[i] <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < NV; i++)
				vld_s[i] <= vld_s[i-1];
			out_vld_q <= vld_s[NV-1];
		end
	end
	assign out_valid = out_vld_q;

	// stage 1: input register
	q_t din [NDIR];
	assign din = '{dist_0, dist_1, dist_2, dist_3, dist_4, dist_5, dist_6, dist_7, dist_8};

	q_t   dist_s1 [NDIR];
	logic solid_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			dist_s1  <= din;
			solid_s1 <= is_solid;
		end
	end

	// stage 2: density and momentum, exact sums then saturate
	logic signed [DW+3:0] rsum, xsum, ysum;
	always_comb begin
		rsum = '0;
		xsum = '0;
		ysum = '0;
		for (int k = 0; k < NDIR; k++) begin
			rsum = rsum + (DW+4)'(dist_s1[k]);
			if (DIR_X[k] > 0)
				xsum = xsum + (DW+4)'(dist_s1[k]);
			else if (DIR_X[k] < 0)
				xsum = xsum - (DW+4)'(dist_s1[k]);
			if (DIR_Y[k] > 0)
				ysum = ysum + (DW+4)'(dist_s1[k]);
			else if (DIR_Y[k] < 0)
				ysum = ysum - (DW+4)'(dist_s1[k]);
		end
	end

	q_t   rho_s2, mx_s2, my_s2;
	q_t   dist_s2 [NDIR];
	logic solid_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			rho_s2   <= sat32(64'(rsum));
			mx_s2    <= sat32(64'(xsum));
			my_s2    <= sat32(64'(ysum));
			dist_s2  <= dist_s1;
			solid_s2 <= solid_s1;
		end
	end

	// velocity dividers
	q_t ux_d, uy_d;
	d2q9_div u_div_x (.clk(clk), .en(en), .num(mx_s2), .den(rho_s2), .quo(ux_d));
	d2q9_div u_div_y (.clk(clk), .en(en), .num(my_s2), .den(rho_s2), .quo(uy_d));

	// side data alongside the dividers
	q_t   dist_dl  [0:DIV_LAT-1][NDIR];
	q_t   rho_dl   [0:DIV_LAT-1];
	logic solid_dl [0:DIV_LAT-1];
	always_ff @(posedge clk) begin
		if (en) begin
			dist_dl[0]  <= dist_s2;
			rho_dl[0]   <= rho_s2;
			solid_dl[0] <= solid_s2;
			for (int i = 1; i < DIV_LAT; i++) begin
				dist_dl[i]  <= dist_dl[i-1];
				rho_dl[i]   <= rho_dl[i-1];
				solid_dl[i] <= solid_dl[i-1];
			end
		end
	end

	// shared |u|^2 term, stages counted from the divider output
	logic signed [63:0] pux_s1, puy_s1, c4p_s3;
	q_t usq_s2, c4_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			pux_s1 <= ux_d * ux_d;
			puy_s1 <= uy_d * uy_d;
			usq_s2 <= sat32(64'(qfloor(pux_s1)) + 64'(qfloor(puy_s1)));
			c4p_s3 <= usq_s2 * C_THREE_HALF;
			c4_s4  <= qfloor(c4p_s3);
		end
	end

	// direction lanes
	q_t lane_res [NDIR];
	q_t lane_d   [NDIR];
	for (genvar k = 0; k < NDIR; k++) begin : g_lane
		d2q9_lane #(.DIR(k)) u_lane (
			.clk     (clk),
			.en      (en),
			.ux      (ux_d),
			.uy      (uy_d),
			.rho     (rho_dl[DIV_LAT-1]),
			.dist_in (dist_dl[DIV_LAT-1][k]),
			.c4      (c4_s4),
			.rate    (rate_q),
			.result  (lane_res[k]),
			.dist_out(lane_d[k])
		);
	end

	// moments alongside the lanes
	q_t   rho_ml   [0:LANE_LAT-1];
	q_t   ux_ml    [0:LANE_LAT-1];
	q_t   uy_ml    [0:LANE_LAT-1];
	logic solid_ml [0:LANE_LAT-1];
	always_ff @(posedge clk) begin
		if (en) begin
			rho_ml[0]   <= rho_dl[DIV_LAT-1];
			ux_ml[0]    <= ux_d;
			uy_ml[0]    <= uy_d;
			solid_ml[0] <= solid_dl[DIV_LAT-1];
			for (int i = 1; i < LANE_LAT; i++) begin
				rho_ml[i]   <= rho_ml[i-1];
				ux_ml[i]    <= ux_ml[i-1];
				uy_ml[i]    <= uy_ml[i-1];
				solid_ml[i] <= solid_ml[i-1];
			end
		end
	end

	// merge: wall nodes bounce back with zero moments, fluid nodes take the lane results
	q_t new_q [NDIR];
	q_t rho_q, ux_q, uy_q;
	always_ff @(posedge clk) begin
		if (en) begin
			if (solid_ml[LANE_LAT-1]) begin
				for (int k = 0; k < NDIR; k++)
					new_q[k] <= lane_d[DIR_OPP[k]];
				rho_q <= '0;
				ux_q  <= '0;
				uy_q  <= '0;
			end else begin
				new_q <= lane_res;
				rho_q <= rho_ml[LANE_LAT-1];
				ux_q  <= ux_ml[LANE_LAT-1];
				uy_q  <= uy_ml[LANE_LAT-1];
			end
		end
	end

	assign new_0      = new_q[0];
	assign new_1      = new_q[1];
	assign new_2      = new_q[2];
	assign new_3      = new_q[3];
	assign new_4      = new_q[4];
	assign new_5      = new_q[5];
	assign new_6      = new_q[6];
	assign new_7      = new_q[7];
	assign new_8      = new_q[8];
	assign density    = rho_q;
	assign velocity_x = ux_q;
	assign velocity_y = uy_q;

	// no velocity without positive density (walls report zero density)
	a_vel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (density <= 0) |-> (velocity_x == 0) && (velocity_y == 0))
		else $error("velocity nonzero with nonpositive density");

	// a result word only appears after the last stage held a valid node
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(vld_s[NV-1]))
		else $error("output valid without a node in the last stage");

	// rate write lands
	a_cfg_wr: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> rate_q == $past(relax_rate))
		else $error("relax rate write lost");

endmodule
`default_nettype wire

>>> tb/tb_d2q9_bgk_node_collision.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_d2q9_bgk_node_collision
// Drives node words into the D2Q9 BGK collision block under random gaps and
// output stalls, predicts every result word in Q16.16 and checks each field.
// ----------------------------------------------------------------------------

typedef struct {
	logic                  solid;
	logic signed [31:0]    f [9];
} node_word_t;

typedef struct {
	logic signed [31:0]    fn [9];
	logic signed [31:0]    rho;
	logic signed [31:0]    ux;
	logic signed [31:0]    uy;
} coll_word_t;

class collision_scoreboard;
	coll_word_t       expected_q[$];
	logic [17:0]      rate;
	int               errors;
	int               n_nodes;
	int               n_checked;
	int               n_solid;
	int               n_rho_nonpos;

	function new();
		rate = 18'd109227;
		errors = 0;
		n_nodes = 0;
		n_checked = 0;
		n_solid = 0;
		n_rho_nonpos = 0;
	endfunction

	static function logic signed [63:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// exact product, floor by 16 bits, saturate
	static function logic signed [63:0] qmul(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [63:0] p;
		p = a * b;
		return clamp32(p >>> 16);
	endfunction

	function coll_word_t collide(input node_word_t nw);
		coll_word_t r;
		logic signed [63:0] d [9];
		logic signed [63:0] rs, mxs, mys, rho, mx, my, ux, uy, usq, c4;
		logic signed [63:0] eu, br, feq, diff, delta;
		int ex [9];
		int ey [9];
		int opp [9];
		logic signed [63:0] w [9];
		ex = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
		ey = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
		opp = '{0, 3, 4, 1, 2, 7, 8, 5, 6};
		w = '{29127, 7282, 7282, 7282, 7282, 1820, 1820, 1820, 1820};
		for (int k = 0; k < 9; k++) d[k] = nw.f[k];
		if (nw.solid) begin
			for (int k = 0; k < 9; k++) r.fn[k] = nw.f[opp[k]];
			r.rho = 0;
			r.ux = 0;
			r.uy = 0;
			return r;
		end
		rs = 0; mxs = 0; mys = 0;
		for (int k = 0; k < 9; k++) begin
			rs += d[k];
			mxs += ex[k] * d[k];
			mys += ey[k] * d[k];
		end
		rho = clamp32(rs);
		mx = clamp32(mxs);
		my = clamp32(mys);
		ux = 0; uy = 0;
		if (rho > 0) begin
			// SV signed division truncates toward zero
			ux = clamp32((mx * 65536) / rho);
			uy = clamp32((my * 65536) / rho);
		end
		usq = clamp32(qmul(ux, ux) + qmul(uy, uy));
		c4 = qmul(98304, usq);
		for (int k = 0; k < 9; k++) begin
			eu = clamp32(ex[k] * ux + ey[k] * uy);
			br = clamp32(65536 + qmul(196608, eu) + qmul(294912, qmul(eu, eu)) - c4);
			feq = qmul(qmul(w[k], rho), br);
			diff = d[k] - feq;
			delta = (diff * $signed({1'b0, rate})) >>> 16;
			r.fn[k] = clamp32(d[k] - delta);
		end
		r.rho = rho;
		r.ux = ux;
		r.uy = uy;
		return r;
	endfunction

	function void note_node(input node_word_t nw);
		coll_word_t r;
		r = collide(nw);
		if (nw.solid) n_solid++;
		else if (r.rho <= 0) n_rho_nonpos++;
		n_nodes++;
		expected_q.push_back(r);
	endfunction

	function void check_word(input coll_word_t act);
		coll_word_t e;
		if (expected_q.size() == 0) begin
			$error("result word with nothing expected");
			errors++;
			return;
		end
		e = expected_q.pop_front();
		n_checked++;
		for (int k = 0; k < 9; k++)
			if (act.fn[k] !== e.fn[k]) begin
				$error("new_%0d: expected %h, got %h", k, e.fn[k], act.fn[k]);
				errors++;
			end
		if (act.rho !== e.rho) begin
			$error("density: expected %h, got %h", e.rho, act.rho);
			errors++;
		end
		if (act.ux !== e.ux) begin
			$error("velocity_x: expected %h, got %h", e.ux, act.ux);
			errors++;
		end
		if (act.uy !== e.uy) begin
			$error("velocity_y: expected %h, got %h", e.uy, act.uy);
			errors++;
		end
	endfunction
endclass

module tb_d2q9_bgk_node_collision;
	import d2q9_pkg::*;

	localparam int PIPE_LAT  = 62;
	localparam int N_RANDOM  = 1250;
	localparam int CYC_LIMIT = 2000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        is_solid = 1'b0;
	q_t          dist_w [9];
	logic        out_valid;
	logic        out_stall = 1'b0;
	q_t          new_w [9];
	q_t          density, velocity_x, velocity_y;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [17:0] relax_rate = '0;

	collision_scoreboard sb;
	int          cycles = 0;
	bit          stall_quiet = 1'b0;   // receiver stops stalling when set
	int          rates_used = 0;

	initial for (int k = 0; k < 9; k++) dist_w[k] = '0;

	always #5 clk = ~clk;

	d2q9_bgk_node_collision uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.is_solid   (is_solid),
		.dist_0     (dist_w[0]),
		.dist_1     (dist_w[1]),
		.dist_2     (dist_w[2]),
		.dist_3     (dist_w[3]),
		.dist_4     (dist_w[4]),
		.dist_5     (dist_w[5]),
		.dist_6     (dist_w[6]),
		.dist_7     (dist_w[7]),
		.dist_8     (dist_w[8]),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.new_0      (new_w[0]),
		.new_1      (new_w[1]),
		.new_2      (new_w[2]),
		.new_3      (new_w[3]),
		.new_4      (new_w[4]),
		.new_5      (new_w[5]),
		.new_6      (new_w[6]),
		.new_7      (new_w[7]),
		.new_8      (new_w[8]),
		.density    (density),
		.velocity_x (velocity_x),
		.velocity_y (velocity_y),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.relax_rate (relax_rate)
	);

	// gap length: most often none, now and then a long hold
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	// monitor: sample result words at the rising edge
	always @(posedge clk) begin
		coll_word_t act;
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			for (int k = 0; k < 9; k++) act.fn[k] = new_w[k];
			act.rho = density;
			act.ux = velocity_x;
			act.uy = velocity_y;
			sb.check_word(act);
		end
	end

	// receiver backpressure, changed on the falling edge
	initial begin
		int n;
		forever begin
			out_stall <= 1'b0;
			n = gap_len();
			if (stall_quiet || $urandom_range(0, 3) == 0) n = 0;
			repeat (n + 1) @(negedge clk);
			if (!stall_quiet && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat (gap_len() + 1) @(negedge clk);
			end
		end
	end

	// present one node word and hold it until accepted; valid stays high
	// afterwards so the next word can follow without a gap
	task automatic send_node(input node_word_t nw, input bit with_gaps);
		int n;
		n = with_gaps ? gap_len() : 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		is_solid <= nw.solid;
		for (int k = 0; k < 9; k++) dist_w[k] <= nw.f[k];
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_node(nw);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (PIPE_LAT + 8) @(negedge clk);
	endtask

	// rate write; the pipe must be empty
	task automatic write_rate(input logic [17:0] r);
		drain();
		cfg_valid <= 1'b1;
		relax_rate <= r;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.rate = r;
		rates_used++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [31:0] rand_dist(input int style);
		case (style)
			0: return $signed($urandom());
			1: return $signed($urandom_range(0, 2 * 65536));   // physical 0..2
			2: return $signed($urandom_range(0, 65536)) - 32768; // small, either sign
			default: return $signed($urandom_range(0, 1 << 24));
		endcase
	endfunction

	function automatic node_word_t rand_node();
		node_word_t nw;
		int style;
		int pick;
		pick = $urandom_range(0, 99);
		style = (pick < 60) ? 1 : (pick < 75) ? 2 : (pick < 88) ? 3 : 0;
		nw.solid = ($urandom_range(0, 6) == 0);
		for (int k = 0; k < 9; k++) nw.f[k] = rand_dist(style);
		return nw;
	endfunction

	task automatic directed_nodes();
		node_word_t nw;
		logic signed [31:0] ext [4];
		ext = '{32'sh7fffffff, 32'sh80000000, 32'sh0, 32'shffffffff};
		// all-equal extremes, fluid and wall
		for (int e = 0; e < 4; e++)
			for (int s = 0; s < 2; s++) begin
				nw.solid = (s != 0);
				for (int k = 0; k < 9; k++) nw.f[k] = ext[e];
				send_node(nw, 0);
			end
		// rest at equilibrium weight
		nw.solid = 0;
		for (int k = 0; k < 9; k++) nw.f[k] = (k == 0) ? 29127 : (k < 5) ? 7282 : 1820;
		send_node(nw, 0);
		// one hot max per direction: strong momentum, velocity saturation
		for (int k = 1; k < 9; k++) begin
			nw.solid = 0;
			for (int j = 0; j < 9; j++) nw.f[j] = (j == k) ? 32'sh7fffffff : 32'sh1;
			send_node(nw, 0);
		end
		// negative density with momentum
		nw.solid = 0;
		for (int k = 0; k < 9; k++) nw.f[k] = -65536;
		nw.f[1] = 65536;
		send_node(nw, 0);
		// tiny positive density, large momentum
		for (int k = 0; k < 9; k++) nw.f[k] = 0;
		nw.f[1] = 32'sh40000000;
		nw.f[3] = -32'sh3fffffff;
		send_node(nw, 0);
		// distinct values through bounce-back
		nw.solid = 1;
		for (int k = 0; k < 9; k++) nw.f[k] = (k + 1) * 1000 - 4000;
		send_node(nw, 0);
	endtask

	initial begin
		logic [17:0] rates [5];
		sb = new();
		rates = '{18'd0, 18'd65536, 18'd131072, 18'h3ffff, 18'd109227};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset rate first, then every other setting
		directed_nodes();
		for (int p = 0; p < 5; p++) begin
			write_rate(rates[p]);
			directed_nodes();
			for (int i = 0; i < N_RANDOM / 8; i++) send_node(rand_node(), 1);
		end
		// sender holds off until the pipe is empty, then back-to-back
		drain();
		stall_quiet = 1'b1;
		for (int i = 0; i < 150; i++) send_node(rand_node(), 0);
		stall_quiet = 1'b0;
		write_rate(18'($urandom_range(0, 131072)));
		for (int i = 0; i < N_RANDOM / 8; i++) send_node(rand_node(), 1);
		write_rate(18'($urandom()));
		for (int i = 0; i < N_RANDOM / 8; i++) send_node(rand_node(), 1);
		drain();

		$display("Run: %0d nodes (%0d wall, %0d nonpositive density), %0d words checked.",
			sb.n_nodes, sb.n_solid, sb.n_rho_nonpos, sb.n_checked);
		$display("Relax rate written %0d times, including 0 and the 18-bit maximum.",
			rates_used);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("tb_d2q9_bgk_node_collision: PASS");
		else
			$display("tb_d2q9_bgk_node_collision: FAIL");
		$finish;
	end

	// watchdog
	always @(posedge clk)
		if (cycles > CYC_LIMIT) begin
			$display("tb_d2q9_bgk_node_collision: FAIL");
			$finish;
		end

endmodule
